@@ hdl/hat_pkg.sv @@
// Shared constants, types and per-stage functions for the Hilbert axes-to-transpose unit.
// Depends on nothing; every other file in this folder imports it.

package hat_pkg;

    localparam int unsigned WORD_W           = 64;
    localparam int unsigned AXES             = 3;
    localparam int unsigned ORDER_BITS       = 60;
    localparam int unsigned TOP_BIT          = (ORDER_BITS - 1) % WORD_W;
    localparam int unsigned LEVELS           = TOP_BIT;
    localparam int unsigned LEVELS_PER_STAGE = 2;
    localparam int unsigned LEVEL_STAGES     =
        (LEVELS + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;
    localparam int unsigned PIPE_STAGES      = LEVEL_STAGES + 2;

    // Bits 1 through TOP_BIT: the bit levels that the correction mask covers.
    localparam logic [WORD_W-1:0] LEVEL_MASK =
        ((64'd2 << TOP_BIT) - 64'd1) & ~64'd1;

    typedef logic [WORD_W-1:0] hat_word_t;
    typedef logic [AXES-1:0][WORD_W-1:0] hat_axes_t;

    // Applies the bit levels that belong to one pipeline stage. Levels run from
    // the top bit downward; a stage past the last level passes its data through.
    function automatic hat_axes_t hat_stage_levels(hat_axes_t v, int unsigned stage);
        hat_axes_t   r;
        int unsigned idx;
        int unsigned bitpos;
        hat_word_t   low;
        hat_word_t   d;
        r = v;
        for (int unsigned l = 0; l < LEVELS_PER_STAGE; l++) begin
            idx = stage * LEVELS_PER_STAGE + l;
            if (idx < LEVELS) begin
                bitpos = TOP_BIT - idx;
                low    = (64'd1 << bitpos) - 64'd1;
                for (int unsigned a = 0; a < AXES; a++) begin
                    if (r[a][bitpos]) begin
                        r[0] = r[0] ^ low;
                    end else begin
                        d    = (r[0] ^ r[a]) & low;
                        r[0] = r[0] ^ d;
                        r[a] = r[a] ^ d;
                    end
                end
            end
        end
        return r;
    endfunction

    // Gray encoding across the axes: each axis absorbs the encoded one before it.
    function automatic hat_axes_t hat_gray(hat_axes_t v);
        hat_axes_t r;
        r = v;
        for (int unsigned a = 1; a < AXES; a++) begin
            r[a] = r[a] ^ r[a-1];
        end
        return r;
    endfunction

    // Correction mask: bit j is the parity of the last axis over the level bits
    // strictly above j. Each bit is an independent reduction.
    function automatic hat_word_t hat_correction(hat_word_t last_axis);
        hat_word_t c;
        hat_word_t above;
        for (int unsigned j = 0; j < WORD_W; j++) begin
            above = ~((64'd2 << j) - 64'd1);
            c[j]  = ^(last_axis & above & LEVEL_MASK);
        end
        return c;
    endfunction

endpackage

@@ hdl/hat_point_if.sv @@
// Valid/ready channel that carries one three-axis coordinate point.
// Depends on hat_pkg for the word type.

interface hat_point_if;
    import hat_pkg::*;

    logic      valid;
    logic      ready;
    hat_word_t axis_x;
    hat_word_t axis_y;
    hat_word_t axis_z;

    modport source (output valid, output axis_x, output axis_y, output axis_z, input ready);
    modport sink   (input valid, input axis_x, input axis_y, input axis_z, output ready);
endinterface

@@ hdl/hat_key_if.sv @@
// Valid/ready channel that carries one transposed Hilbert index (three words).
// Depends on hat_pkg for the word type.

interface hat_key_if;
    import hat_pkg::*;

    logic      valid;
    logic      ready;
    hat_word_t key_word0;
    hat_word_t key_word1;
    hat_word_t key_word2;

    modport source (output valid, output key_word0, output key_word1, output key_word2,
                    input ready);
    modport sink   (input valid, input key_word0, input key_word1, input key_word2,
                    output ready);
endinterface

@@ hdl/hilbert_axes_to_transpose_unit.sv @@
// Channel    Interface            Direction  Payload
// in_point   hat_point_if.sink    input      axis_x, axis_y, axis_z (64 bits each)
// out_key    hat_key_if.source    output     key_word0, key_word1, key_word2 (64 bits each)
//
// One point is taken per cycle while the output flows. In the pipeline, each level
// stage resolves two bit levels, then one stage Gray encodes and one stage applies
// the correction mask and holds the result. A stall at the output freezes the whole
// pipeline; one transfer that arrives during the stall waits in a skid register, so
// in_point.ready is a register. Reset clears the valid bits, the skid valid flag and
// the input ready register only.
// Depends on hat_pkg, hat_point_if and hat_key_if.

module hilbert_axes_to_transpose_unit
    import hat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    hat_point_if.sink        in_point,
    hat_key_if.source        out_key
);

    // The pipeline advances as one unit whenever the output register is empty
    // or its content is being taken in this cycle.
    logic pipe_en;
    logic in_xfer;

    // Skid register in front of the first stage. It holds one point that was
    // accepted while the pipeline stood still.
    logic      skid_valid_reg;
    logic      skid_valid_next;
    hat_axes_t skid_data_reg;
    logic      in_ready_reg;

    // Head of the pipeline: the skid entry when present, else the live input.
    logic      head_valid;
    hat_axes_t head_data;

    // Valid bits travel with the data, one per stage.
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;

    // Level stages, then Gray stage, then output stage.
    hat_axes_t lvl_in   [LEVEL_STAGES];
    hat_axes_t lvl_next [LEVEL_STAGES];
    hat_axes_t lvl_reg  [LEVEL_STAGES];
    hat_axes_t gray_next;
    hat_axes_t gray_reg;
    hat_axes_t out_next;
    hat_axes_t out_reg;
    hat_word_t corr_mask;

    assign pipe_en = !valid_reg[PIPE_STAGES-1] || out_key.ready;
    assign in_xfer = in_point.valid && in_ready_reg;

    always_comb
    begin
        if (skid_valid_reg)
        begin
            head_valid = 1'b1;
            head_data  = skid_data_reg;
        end
        else
        begin
            head_valid = in_xfer;
            head_data  = {in_point.axis_z, in_point.axis_y, in_point.axis_x};
        end
    end

    // A transfer taken while the pipeline is frozen parks in the skid register;
    // the skid drains as soon as the pipeline moves again.
    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (pipe_en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (in_xfer)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            in_ready_reg   <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            in_ready_reg   <= !skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!pipe_en && in_xfer)
        begin
            skid_data_reg <= head_data;
        end
    end

    assign in_point.ready = in_ready_reg;

    // Each level stage handles two bit levels, top bit first. The last stage
    // may carry only one real level when the level count is odd.
    assign lvl_in[0] = head_data;

    for (genvar s = 0; s < LEVEL_STAGES; s++)
    begin : g_level
        if (s > 0)
        begin : g_chain
            assign lvl_in[s] = lvl_reg[s-1];
        end

        always_comb
        begin
            lvl_next[s] = hat_stage_levels(lvl_in[s], s);
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                lvl_reg[s] <= lvl_next[s];
            end
        end
    end

    always_comb
    begin
        gray_next = hat_gray(lvl_reg[LEVEL_STAGES-1]);
    end

    // The correction mask depends only on the Gray-encoded last axis; every
    // bit of it is an independent parity, so it fits in one stage.
    always_comb
    begin
        corr_mask = hat_correction(gray_reg[AXES-1]);
        for (int unsigned a = 0; a < AXES; a++)
        begin
            out_next[a] = gray_reg[a] ^ corr_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            gray_reg <= gray_next;
            out_reg  <= out_next;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pipe_en)
        begin
            valid_next = {valid_reg[PIPE_STAGES-2:0], head_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_key.valid     = valid_reg[PIPE_STAGES-1];
    assign out_key.key_word0 = out_reg[0];
    assign out_key.key_word1 = out_reg[1];
    assign out_key.key_word2 = out_reg[2];

    // A point parked in the skid register stays there until the pipeline moves.
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !pipe_en |=> skid_valid_reg)
        else $error("skid entry lost while the pipeline was frozen");

    // A transfer taken during a freeze must land in the skid register.
    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !pipe_en |=> skid_valid_reg)
        else $error("input transfer dropped during a pipeline freeze");

    // When the pipeline moves, a parked point enters the first stage.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pipe_en |=> valid_reg[0] && !skid_valid_reg)
        else $error("skid entry did not enter the first stage");

    // A frozen pipeline keeps its valid pattern unchanged.
    a_freeze_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> valid_reg == $past(valid_reg))
        else $error("valid bits changed while the pipeline was frozen");

endmodule
